/* design/prc_pkg.sv */
// Shared types, constants and the quarter-wave sine table for the PR control step.
// Used by prc_mul, prc_div and inverter_pr_control_step_core; depends on nothing.
package prc_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int QB              = SINE_TABLE_BITS - 2;
  localparam int QUARTER         = 1 << QB;
  localparam int PWM_PERIOD      = 4199;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int SAMPLE_SHIFT    = 31 - SAMPLE_WIDTH;
  localparam int MUL_W           = 33;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int DRIVE_LIMIT     = 14746;
  localparam int Q14_ONE         = 16384;
  localparam int Q_NUM_W         = 32;
  localparam int DEN_W           = 17;

  localparam longint unsigned K1 = 64'd1686629713;
  localparam longint unsigned K3 = 64'd693598668;
  localparam longint unsigned K5 = 64'd85569306;
  localparam longint unsigned K7 = 64'd5026995;
  localparam longint unsigned K9 = 64'd172272;

  typedef enum logic [1:0] {
    MODE_OPEN,
    MODE_VOLT,
    MODE_CURR,
    MODE_CASCADE
  } loop_mode_e;

  typedef enum logic [2:0] {
    CFG_LOOP_MODE,
    CFG_RES_COEFS,
    CFG_VOLT_GAINS,
    CFG_CURR_GAINS,
    CFG_PHASE_STEP,
    CFG_AMP_TARGET,
    CFG_RAMP,
    CFG_LOAD_G
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_MREF,
    ST_REF,
    ST_MG,
    ST_GREF,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_DIVS,
    ST_DIVW,
    ST_CA,
    ST_CB,
    ST_DONE
  } seq_state_e;

  typedef logic [14:0] qtab_t [0:QUARTER];

  // Q15 magnitude of sin(pi/2 * zr / QUARTER), 9th order odd polynomial in Q30.
  function automatic logic [14:0] sine_mag(int unsigned zr);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned v;
    z  = longint'(zr) << (30 - QB);
    z2 = (z * z) >> 30;
    p  = K7 - ((z2 * K9) >> 30);
    p  = K5 - ((z2 * p) >> 30);
    p  = K3 - ((z2 * p) >> 30);
    p  = K1 - ((z2 * p) >> 30);
    v  = (((z * p) >> 30) + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k <= QUARTER; k++) begin
      t[k] = sine_mag(k);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

/* design/prc_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on prc_pkg for the operand width.
module prc_mul (
  input  logic                               clk_i,
  input  logic signed [prc_pkg::MUL_W-1:0]   a_i,
  input  logic signed [prc_pkg::MUL_W-1:0]   b_i,
  output logic signed [prc_pkg::PROD_W-1:0]  p_o
);

  logic signed [prc_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= prc_pkg::PROD_W'(a_i) * prc_pkg::PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

/* design/prc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on prc_pkg for the dividend and divisor widths.
module prc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [prc_pkg::Q_NUM_W-1:0]       num_i,
  input  logic [prc_pkg::DEN_W-1:0]         den_i,
  output logic                              done_o,
  output logic [prc_pkg::Q_NUM_W-1:0]       quo_o
);

  localparam int CNT_W = $clog2(prc_pkg::Q_NUM_W);

  logic                            busy_q;
  logic                            done_q;
  logic [CNT_W-1:0]                cnt_q;
  logic [prc_pkg::DEN_W-1:0]       den_q;
  logic [prc_pkg::DEN_W-1:0]       rem_q;
  logic [prc_pkg::Q_NUM_W-1:0]     quo_q;
  logic [prc_pkg::DEN_W:0]         shifted;
  logic                            fits;

  assign shifted = {rem_q, quo_q[prc_pkg::Q_NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(prc_pkg::Q_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? prc_pkg::DEN_W'(shifted - {1'b0, den_q}) : shifted[prc_pkg::DEN_W-1:0];
      quo_q <= {quo_q[prc_pkg::Q_NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* design/inverter_pr_control_step_core.sv */
// Top level of the dual-loop PR inverter control step: sequencer and datapath.
// Depends on prc_pkg, prc_mul (shared multiplier) and prc_div (bus divider).
//
// Usage: one input item per PWM period carries the restart flag and the inductor
// current, output voltage and bus voltage samples. An item is accepted when
// in_valid_i is high and in_stall_o is low; a result item leaves when out_valid_o
// is high and out_stall_i is low. Configuration registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i in one cycle; the user must write them only
// while the block is idle, which the block itself does not enforce.
//
// The single shared multiplier serves every product in turn (four per PR stage)
// and the divider yields one quotient bit per cycle, so an item takes the fewest
// steps in open loop and the most in cascade mode with a nonzero bus voltage. The
// block takes one item at a time: in_stall_o is high from acceptance until the
// result is loaded into the output register. A finished result may wait in the
// output register while the next item is accepted; when the receiver stalls with
// a result still waiting, the sequencer holds its finished item in the last step
// until the output register frees.
//
// Reset clears the phase accumulator, amplitude, ramp count, filter histories
// and control state and loads the register reset values; the sine table is a
// constant quarter-wave table, so no fill pass is needed.
module inverter_pr_control_step_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [2:0]                              cfg_idx_i,
  input  logic [63:0]                             cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    restart_i,
  input  logic signed [prc_pkg::SAMPLE_WIDTH-1:0] il_sample_i,
  input  logic signed [prc_pkg::SAMPLE_WIDTH-1:0] vout_sample_i,
  input  logic [15:0]                             bus_voltage_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [14:0]                      drive_cmd_o,
  output logic signed [15:0]                      ref_inst_o,
  output logic signed [15:0]                      current_ref_o,
  output logic [12:0]                             compare_a_o,
  output logic [12:0]                             compare_b_o,
  output logic                                    div_fault_o
);

  localparam int MW = prc_pkg::MUL_W;
  localparam int PW = prc_pkg::PROD_W;
  localparam int SW = prc_pkg::SAMPLE_WIDTH;

  function automatic logic signed [15:0] sat16(logic signed [39:0] x);
    logic signed [15:0] r;
    if (x > 40'sd32767) begin
      r = 16'sd32767;
    end else if (x < -40'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'sh007fffffff) begin
      r = 32'sh7fffffff;
    end else if (x < -40'sh0080000000) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  prc_pkg::loop_mode_e  mode_q;
  logic [63:0]          res_coef_q;
  logic [63:0]          vgain_q;
  logic [63:0]          cgain_q;
  logic [31:0]          phase_step_q;
  logic [14:0]          amp_target_q;
  logic [31:0]          ramp_q;
  logic [15:0]          load_g_q;

  // Runtime state.
  logic [31:0]          phase_q;
  logic [14:0]          amp_q;
  logic [15:0]          cnt_q;
  logic signed [31:0]   vh1_q, vh2_q, ch1_q, ch2_q;

  // Sequencer and item registers.
  prc_pkg::seq_state_e  state_q, state_d;
  logic                 restart_q;
  logic signed [SW-1:0] il_q, vo_q;
  logic [15:0]          bus_q;
  logic signed [15:0]   sine_q;
  logic signed [15:0]   ref_q;
  logic signed [15:0]   iref_q;
  logic signed [MW-1:0] e_q;
  logic signed [37:0]   acc_q;
  logic signed [31:0]   w0_q;
  logic signed [31:0]   y_q;
  logic                 pr_curr_q;
  logic signed [14:0]   drive_q;
  logic                 fault_q;
  logic [12:0]          ca_q;

  // Output register.
  logic                 out_valid_q;
  logic signed [14:0]   o_drive_q;
  logic signed [15:0]   o_ref_q, o_iref_q;
  logic [12:0]          o_ca_q, o_cb_q;
  logic                 o_fault_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 load_out;

  assign in_acc   = in_valid_i && (state_q == prc_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == prc_pkg::ST_DONE) && out_free;

  // Multiplier and divider.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [35:0]   prod_q30;
  logic signed [33:0]   prod_lo;
  logic                 div_start;
  logic                 div_done;
  logic [31:0]          div_num;
  logic [31:0]          div_quo;

  prc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  prc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({bus_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign prod_q30 = prod[PW-1:30];
  assign prod_lo  = prod[33:0];

  // Selected PR stage operands.
  logic signed [31:0]   a1, a2, kp, kr, h1, h2;
  logic [63:0]          gains;

  assign gains = pr_curr_q ? cgain_q : vgain_q;
  assign a1    = res_coef_q[63:32];
  assign a2    = res_coef_q[31:0];
  assign kp    = gains[63:32];
  assign kr    = gains[31:0];
  assign h1    = pr_curr_q ? ch1_q : vh1_q;
  assign h2    = pr_curr_q ? ch2_q : vh2_q;

  // Restart applies before the step.
  logic [31:0]          phase_eff;
  logic [14:0]          amp_eff;
  logic [15:0]          cnt_eff;

  assign phase_eff = restart_q ? '0 : phase_q;
  assign amp_eff   = restart_q ? '0 : amp_q;
  assign cnt_eff   = restart_q ? '0 : cnt_q;

  // Sine lookup by quadrant folding of the quarter-wave table.
  logic [prc_pkg::SINE_TABLE_BITS-1:0] sidx;
  logic [1:0]                          quad;
  logic [prc_pkg::QB:0]                zr;
  logic [14:0]                         smag;
  logic signed [15:0]                  sine_d;

  assign sidx   = phase_eff[31 -: prc_pkg::SINE_TABLE_BITS];
  assign quad   = sidx[prc_pkg::SINE_TABLE_BITS-1 -: 2];
  assign zr     = quad[0] ? (prc_pkg::QB+1)'(prc_pkg::QUARTER) - {1'b0, sidx[prc_pkg::QB-1:0]}
                          : {1'b0, sidx[prc_pkg::QB-1:0]};
  assign smag   = prc_pkg::QTAB[zr];
  assign sine_d = quad[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

  // Amplitude ramp.
  logic [15:0]          cnt_inc;
  logic [16:0]          amp_sum;
  logic [14:0]          amp_d;
  logic [15:0]          cnt_d;

  always_comb begin
    cnt_inc = cnt_eff + 16'd1;
    amp_sum = {2'b00, amp_eff} + {1'b0, ramp_q[15:0]};
    amp_d   = amp_eff;
    cnt_d   = cnt_eff;
    if (amp_eff >= amp_target_q) begin
      amp_d = amp_target_q;
    end else if (cnt_inc >= ramp_q[31:16]) begin
      cnt_d = '0;
      amp_d = (amp_sum > {2'b00, amp_target_q}) ? amp_target_q : amp_sum[14:0];
    end else begin
      cnt_d = cnt_inc;
    end
  end

  // Reference rounding, open-loop drive and the derived current references.
  logic signed [33:0]   rsum, osum, gsum;
  logic signed [15:0]   ref_d;
  logic signed [15:0]   open_raw;
  logic signed [14:0]   open_drive;
  logic signed [15:0]   gref;
  logic signed [32:0]   ysum;
  logic signed [15:0]   yref;
  logic signed [37:0]   w0_full, y_full;
  logic signed [31:0]   y_d;

  assign rsum     = prod_lo + 34'sd16384;
  assign osum     = prod_lo + 34'sd32768;
  assign gsum     = prod_lo + 34'sd128;
  assign ref_d    = rsum[30:15];
  assign open_raw = osum[31:16];
  assign open_drive = (open_raw > 16'sd14746) ? 15'sd14746 :
                      (open_raw < -16'sd14746) ? -15'sd14746 : open_raw[14:0];
  assign gref     = sat16(40'(gsum >>> 8));
  assign w0_full  = acc_q - 38'(prod_q30);
  assign y_full   = acc_q + 38'(prod_q30);
  assign y_d      = sat32(40'(y_full));
  assign ysum     = 33'(y_d) + 33'sd16384;
  assign yref     = sat16(40'(ysum >>> 15));

  function automatic logic signed [MW-1:0] err(logic signed [15:0] r, logic signed [SW-1:0] s);
    return (MW'(r) <<< 15) - (MW'(s) <<< prc_pkg::SAMPLE_SHIFT);
  endfunction

  // Division result, saturated to the drive limit.
  logic [31:0]          qsat;
  assign qsat     = (div_quo > 32'(prc_pkg::DRIVE_LIMIT)) ? 32'(prc_pkg::DRIVE_LIMIT) : div_quo;
  assign div_num  = y_q[31] ? 32'(-y_q) : 32'(y_q);

  // Next state and the multiplier operands for each step.
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      prc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = prc_pkg::ST_PREP;
        end
      end
      prc_pkg::ST_PREP: state_d = prc_pkg::ST_MREF;
      prc_pkg::ST_MREF: begin
        mul_a   = MW'($signed({1'b0, amp_q}));
        mul_b   = MW'(sine_q);
        state_d = prc_pkg::ST_REF;
      end
      prc_pkg::ST_REF: begin
        case (mode_q)
          prc_pkg::MODE_OPEN: state_d = prc_pkg::ST_CA;
          prc_pkg::MODE_CURR: state_d = prc_pkg::ST_MG;
          default:            state_d = prc_pkg::ST_P1;
        endcase
      end
      prc_pkg::ST_MG: begin
        mul_a   = MW'(ref_q);
        mul_b   = MW'($signed({1'b0, load_g_q}));
        state_d = prc_pkg::ST_GREF;
      end
      prc_pkg::ST_GREF: state_d = prc_pkg::ST_P1;
      prc_pkg::ST_P1: begin
        mul_a   = MW'(a1);
        mul_b   = MW'(h1);
        state_d = prc_pkg::ST_P2;
      end
      prc_pkg::ST_P2: begin
        mul_a   = MW'(a2);
        mul_b   = MW'(h2);
        state_d = prc_pkg::ST_P3;
      end
      prc_pkg::ST_P3: begin
        mul_a   = MW'(kp);
        mul_b   = e_q;
        state_d = prc_pkg::ST_P4;
      end
      prc_pkg::ST_P4: begin
        mul_a   = MW'(kr);
        mul_b   = MW'(w0_q) - MW'(h2);
        state_d = prc_pkg::ST_P5;
      end
      prc_pkg::ST_P5: begin
        if (!pr_curr_q && (mode_q == prc_pkg::MODE_CASCADE)) begin
          state_d = prc_pkg::ST_P1;
        end else begin
          state_d = prc_pkg::ST_DIVS;
        end
      end
      prc_pkg::ST_DIVS: begin
        if (bus_q == '0) begin
          state_d = prc_pkg::ST_CA;
        end else begin
          div_start = 1'b1;
          state_d   = prc_pkg::ST_DIVW;
        end
      end
      prc_pkg::ST_DIVW: begin
        if (div_done) begin
          state_d = prc_pkg::ST_CA;
        end
      end
      prc_pkg::ST_CA: begin
        mul_a   = MW'(17'(prc_pkg::Q14_ONE) + 17'(drive_q));
        mul_b   = MW'(prc_pkg::PWM_PERIOD);
        state_d = prc_pkg::ST_CB;
      end
      prc_pkg::ST_CB: begin
        mul_a   = MW'(17'(prc_pkg::Q14_ONE) - 17'(drive_q));
        mul_b   = MW'(prc_pkg::PWM_PERIOD);
        state_d = prc_pkg::ST_DONE;
      end
      prc_pkg::ST_DONE: begin
        // Keep the leg B operands so the product stays put while the output waits.
        mul_a   = MW'(17'(prc_pkg::Q14_ONE) - 17'(drive_q));
        mul_b   = MW'(prc_pkg::PWM_PERIOD);
        if (out_free) begin
          state_d = prc_pkg::ST_IDLE;
        end
      end
      default: state_d = prc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration and runtime state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= prc_pkg::MODE_CASCADE;
      res_coef_q   <= '0;
      vgain_q      <= '0;
      cgain_q      <= '0;
      phase_step_q <= 32'd10737418;
      amp_target_q <= 15'd16384;
      ramp_q       <= 32'd1310884;
      load_g_q     <= 16'd256;
      phase_q      <= '0;
      amp_q        <= '0;
      cnt_q        <= '0;
      vh1_q        <= '0;
      vh2_q        <= '0;
      ch1_q        <= '0;
      ch2_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (prc_pkg::cfg_idx_e'(cfg_idx_i))
          prc_pkg::CFG_LOOP_MODE:  mode_q       <= prc_pkg::loop_mode_e'(cfg_data_i[1:0]);
          prc_pkg::CFG_RES_COEFS:  res_coef_q   <= cfg_data_i;
          prc_pkg::CFG_VOLT_GAINS: vgain_q      <= cfg_data_i;
          prc_pkg::CFG_CURR_GAINS: cgain_q      <= cfg_data_i;
          prc_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data_i[31:0];
          prc_pkg::CFG_AMP_TARGET: amp_target_q <= cfg_data_i[14:0];
          prc_pkg::CFG_RAMP:       ramp_q       <= cfg_data_i[31:0];
          prc_pkg::CFG_LOAD_G:     load_g_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == prc_pkg::ST_PREP) begin
        phase_q <= phase_eff + phase_step_q;
        amp_q   <= amp_d;
        cnt_q   <= cnt_d;
        if (restart_q) begin
          vh1_q <= '0;
          vh2_q <= '0;
          ch1_q <= '0;
          ch2_q <= '0;
        end
      end
      if (state_q == prc_pkg::ST_P5) begin
        if (pr_curr_q) begin
          ch2_q <= ch1_q;
          ch1_q <= w0_q;
        end else begin
          vh2_q <= vh1_q;
          vh1_q <= w0_q;
        end
      end
    end
  end

  // Item datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      prc_pkg::ST_IDLE: begin
        restart_q <= restart_i;
        il_q      <= il_sample_i;
        vo_q      <= vout_sample_i;
        bus_q     <= bus_voltage_i;
      end
      prc_pkg::ST_PREP: sine_q <= sine_d;
      prc_pkg::ST_REF: begin
        ref_q     <= ref_d;
        iref_q    <= '0;
        fault_q   <= 1'b0;
        drive_q   <= open_drive;
        e_q       <= err(ref_d, vo_q);
        pr_curr_q <= 1'b0;
      end
      prc_pkg::ST_GREF: begin
        iref_q    <= gref;
        e_q       <= err(gref, il_q);
        pr_curr_q <= 1'b1;
      end
      prc_pkg::ST_P2: acc_q <= 38'(e_q) - 38'(prod_q30);
      prc_pkg::ST_P3: w0_q  <= sat32(40'(w0_full));
      prc_pkg::ST_P4: acc_q <= 38'(prod_q30);
      prc_pkg::ST_P5: begin
        y_q <= y_d;
        if (!pr_curr_q && (mode_q == prc_pkg::MODE_CASCADE)) begin
          iref_q    <= yref;
          e_q       <= err(yref, il_q);
          pr_curr_q <= 1'b1;
        end
      end
      prc_pkg::ST_DIVS: begin
        fault_q <= (bus_q == '0);
        drive_q <= y_q[31] ? -15'sd14746 : ((y_q == '0) ? 15'sd0 : 15'sd14746);
      end
      prc_pkg::ST_DIVW: begin
        drive_q <= y_q[31] ? -$signed(qsat[14:0]) : $signed(qsat[14:0]);
      end
      prc_pkg::ST_CB: ca_q <= prod[27:15];
      default: ;
    endcase
  end

  // Output register: holds a finished item until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_drive_q <= drive_q;
      o_ref_q   <= ref_q;
      o_iref_q  <= iref_q;
      o_ca_q    <= ca_q;
      o_cb_q    <= prod[27:15];
      o_fault_q <= fault_q;
    end
  end

  assign in_stall_o    = (state_q != prc_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign drive_cmd_o   = o_drive_q;
  assign ref_inst_o    = o_ref_q;
  assign current_ref_o = o_iref_q;
  assign compare_a_o   = o_ca_q;
  assign compare_b_o   = o_cb_q;
  assign div_fault_o   = o_fault_q;

endmodule
